FILE: src/lvsa_pkg.sv
// package for the lru voice slot allocator
// holds the beat field widths, function codes and the request/response structs
package lvsa_pkg;

    localparam int FUNC_W     = 1;
    localparam int NOTE_W     = 7;
    localparam int SLOT_IDX_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ACTIVATE   = 1'b0,
        FUNC_DEACTIVATE = 1'b1
    } func_t;

    typedef struct packed {
        func_t                 func;
        logic [SLOT_IDX_W-1:0] slot_index;
    } lvsa_req_t;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot_used;
        logic                  stolen;
        logic                  error;
    } lvsa_rsp_t;

endpackage

FILE: src/lru_voice_slot_allocator_core.sv
// lru voice slot allocator: free list plus age list with oldest-slot stealing
// a beat passes the input register, then the result register, to the result beat
// throughput: one beat per cycle unless the result side stalls; the table updates once
// per beat between the two registers, so back-to-back beats see each other's updates
// reset: synchronous active-low aresetn; all slots free, age list empty
// depends on lvsa_pkg and lvsa_slot_table
module lru_voice_slot_allocator_core #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [lvsa_pkg::FUNC_W-1:0]        s_func,
    input  logic [lvsa_pkg::NOTE_W-1:0]        s_note_number,
    input  logic [lvsa_pkg::SLOT_IDX_W-1:0]    s_slot_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [lvsa_pkg::SLOT_IDX_W-1:0]    m_slot_used,
    output logic                               m_stolen,
    output logic                               m_error
);
    import lvsa_pkg::*;

    logic      in_valid_reg;
    lvsa_req_t in_req_reg;
    logic      out_valid_reg;
    lvsa_rsp_t out_rsp_reg;
    lvsa_rsp_t rsp;
    logic      advance;

    // note number is not kept: nothing ever reads it back
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    lvsa_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (advance),
        .req       (in_req_reg),
        .rsp       (rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.func       <= func_t'(s_func);
            in_req_reg.slot_index <= s_slot_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_slot_used = out_rsp_reg.slot_used;
    assign m_stolen    = out_rsp_reg.stolen;
    assign m_error     = out_rsp_reg.error;

endmodule

FILE: src/lvsa_slot_table.sv
// slot table: age list links, free list, active bits and their update logic
// depends on lvsa_pkg
module lvsa_slot_table #(
    parameter int NUM_SLOTS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    input  lvsa_pkg::lvsa_req_t req,
    output lvsa_pkg::lvsa_rsp_t rsp
);
    import lvsa_pkg::*;

    localparam int W  = $clog2(NUM_SLOTS);
    localparam int LW = W + 1;
    localparam logic [LW-1:0] NIL = {LW{1'b1}};

    logic [LW-1:0]        newer_link_reg [NUM_SLOTS];
    logic [LW-1:0]        newer_link_next[NUM_SLOTS];
    logic [LW-1:0]        older_link_reg [NUM_SLOTS];
    logic [LW-1:0]        older_link_next[NUM_SLOTS];
    logic [NUM_SLOTS-1:0] slot_active_reg;
    logic [NUM_SLOTS-1:0] slot_active_next;
    logic [LW-1:0]        free_head_reg,   free_head_next;
    logic [LW-1:0]        newest_head_reg, newest_head_next;
    logic [LW-1:0]        oldest_slot_reg, oldest_slot_next;

    logic [W-1:0]  s;
    logic [LW-1:0] s_link;
    logic [LW-1:0] p;
    logic [LW-1:0] n;
    logic          idx_ok;

    function automatic logic link_ok(input logic [LW-1:0] x);
        return x < LW'(NUM_SLOTS);
    endfunction

    assign idx_ok = 32'(req.slot_index) < 32'(NUM_SLOTS);
    assign s_link = LW'(s);

    always_comb begin
        newer_link_next  = newer_link_reg;
        older_link_next  = older_link_reg;
        slot_active_next = slot_active_reg;
        free_head_next   = free_head_reg;
        newest_head_next = newest_head_reg;
        oldest_slot_next = oldest_slot_reg;
        s                = '0;
        p                = NIL;
        n                = NIL;
        rsp              = '0;

        if (req.func == FUNC_ACTIVATE) begin
            if (!link_ok(free_head_reg)) begin
                // free list empty: reuse the oldest active slot
                s = link_ok(oldest_slot_reg) ? oldest_slot_reg[W-1:0] : '0;
                oldest_slot_next = newer_link_next[s];
                if (link_ok(oldest_slot_next)) begin
                    older_link_next[oldest_slot_next[W-1:0]] = NIL;
                end
                rsp.stolen = 1'b1;
            end else begin
                s = free_head_reg[W-1:0];
                if (!link_ok(newest_head_reg)) begin
                    oldest_slot_next = free_head_reg;
                end
                free_head_next = older_link_next[s];
            end
            // link in as newest
            if (link_ok(newest_head_reg)) begin
                newer_link_next[newest_head_reg[W-1:0]] = s_link;
            end
            newer_link_next[s] = NIL;
            older_link_next[s] = newest_head_reg;
            newest_head_next   = s_link;
            slot_active_next[s] = 1'b1;
            rsp.slot_used = SLOT_IDX_W'(s);
        end else begin
            rsp.slot_used = req.slot_index;
            s = W'(req.slot_index);
            if (!idx_ok || !slot_active_reg[s]) begin
                rsp.error = 1'b1;
            end else begin
                p = newer_link_reg[s];
                n = older_link_reg[s];
                if (s_link == oldest_slot_reg) begin
                    oldest_slot_next = p;
                end
                if (!link_ok(p)) begin
                    newest_head_next = n;
                    if (link_ok(n)) begin
                        newer_link_next[n[W-1:0]] = NIL;
                    end
                end else begin
                    older_link_next[p[W-1:0]] = n;
                    if (link_ok(n)) begin
                        newer_link_next[n[W-1:0]] = p;
                    end
                end
                older_link_next[s]  = free_head_reg;
                free_head_next      = s_link;
                newer_link_next[s]  = NIL;
                slot_active_next[s] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                newer_link_reg[i] <= NIL;
                older_link_reg[i] <= (i == NUM_SLOTS - 1) ? NIL : LW'(i + 1);
            end
            slot_active_reg <= '0;
            free_head_reg   <= '0;
            newest_head_reg <= NIL;
            oldest_slot_reg <= NIL;
        end else if (req_valid) begin
            newer_link_reg  <= newer_link_next;
            older_link_reg  <= older_link_next;
            slot_active_reg <= slot_active_next;
            free_head_reg   <= free_head_next;
            newest_head_reg <= newest_head_next;
            oldest_slot_reg <= oldest_slot_next;
        end
    end

endmodule

FILE: tb/sv/lru_voice_slot_allocator_checker.sv
// checker for the lru voice slot allocator: watches both channels, keeps its own
// copy of the free list and age list, and compares every result beat in order
// depends on lvsa_pkg
module lru_voice_slot_allocator_checker #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [lvsa_pkg::FUNC_W-1:0]     s_func,
    input  logic [lvsa_pkg::NOTE_W-1:0]     s_note_number,
    input  logic [lvsa_pkg::SLOT_IDX_W-1:0] s_slot_index,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [lvsa_pkg::SLOT_IDX_W-1:0] m_slot_used,
    input  logic                            m_stolen,
    input  logic                            m_error,
    output int                              fail_count,
    output int                              pending
);
    import lvsa_pkg::*;

    localparam logic [4:0] NO_SLOT = 5'h1f;

    logic [4:0] newer_link [NUM_SLOTS];
    logic [4:0] older_link [NUM_SLOTS];
    logic       slot_active [NUM_SLOTS];
    logic [4:0] free_head;
    logic [4:0] newest_head;
    logic [4:0] oldest_slot;

    lvsa_rsp_t  slot_grants [$];
    int         fails = 0;
    int         in_flight = 0;

    assign fail_count = fails;
    assign pending    = in_flight;

    function automatic bit is_slot(logic [4:0] s);
        return s < NUM_SLOTS;
    endfunction

    function automatic void make_newest(logic [4:0] s);
        if (is_slot(newest_head))
            newer_link[newest_head] = s;
        newer_link[s] = NO_SLOT;
        older_link[s] = newest_head;
        newest_head   = s;
    endfunction

    // one beat of allocator behavior: updates the shadow tables, returns the grant
    function automatic lvsa_rsp_t apply_voice_event(func_t f, logic [SLOT_IDX_W-1:0] idx);
        lvsa_rsp_t  r;
        logic [4:0] s;
        logic [4:0] p;
        logic [4:0] n;
        r = '0;
        if (f == FUNC_ACTIVATE) begin
            if (!is_slot(free_head)) begin
                // no free slot: reuse the oldest one
                s = oldest_slot;
                if (!is_slot(s))
                    s = '0;
                oldest_slot = newer_link[s];
                if (is_slot(oldest_slot))
                    older_link[oldest_slot] = NO_SLOT;
                make_newest(s);
                r.stolen = 1'b1;
            end else begin
                s = free_head;
                if (!is_slot(newest_head))
                    oldest_slot = s;
                free_head = older_link[s];
                make_newest(s);
            end
            slot_active[s] = 1'b1;
        end else begin
            s = {1'b0, idx};
            if (!is_slot(s) || !slot_active[s]) begin
                r.error = 1'b1;
            end else begin
                p = newer_link[s];
                n = older_link[s];
                if (s == oldest_slot)
                    oldest_slot = p;
                if (!is_slot(p)) begin
                    newest_head = n;
                    if (is_slot(n))
                        newer_link[n] = NO_SLOT;
                end else begin
                    older_link[p] = n;
                    if (is_slot(n))
                        newer_link[n] = p;
                end
                older_link[s]  = free_head;
                free_head      = s;
                newer_link[s]  = NO_SLOT;
                slot_active[s] = 1'b0;
            end
        end
        r.slot_used = s[SLOT_IDX_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        lvsa_rsp_t want;
        if (!aresetn) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                newer_link[k]  = NO_SLOT;
                older_link[k]  = (k == NUM_SLOTS - 1) ? NO_SLOT : 5'(k + 1);
                slot_active[k] = 1'b0;
            end
            free_head   = '0;
            newest_head = NO_SLOT;
            oldest_slot = NO_SLOT;
            slot_grants.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (slot_grants.size() == 0) begin
                    $error("result beat with nothing expected: slot_used %0d", m_slot_used);
                    fails++;
                end else begin
                    want = slot_grants.pop_front();
                    if (m_slot_used !== want.slot_used) begin
                        $error("slot_used: expected %0d, got %0d", want.slot_used, m_slot_used);
                        fails++;
                    end
                    if (m_stolen !== want.stolen) begin
                        $error("stolen: expected %0b, got %0b", want.stolen, m_stolen);
                        fails++;
                    end
                    if (m_error !== want.error) begin
                        $error("error: expected %0b, got %0b", want.error, m_error);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready)
                slot_grants.push_back(apply_voice_event(func_t'(s_func), s_slot_index));
        end
        in_flight <= slot_grants.size();
    end

endmodule

FILE: tb/sv/lru_voice_slot_allocator_core_tb.sv
// top of the lru voice slot allocator testbench: clock, reset, note events and
// result back-pressure; checking lives in lru_voice_slot_allocator_checker
// depends on lvsa_pkg, lru_voice_slot_allocator_core and the checker
module lru_voice_slot_allocator_core_tb;
    import lvsa_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 14;
    localparam int PHASE_BEATS  = 50;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [FUNC_W-1:0]     s_func        = FUNC_ACTIVATE;
    logic [NOTE_W-1:0]     s_note_number = '0;
    logic [SLOT_IDX_W-1:0] s_slot_index  = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [SLOT_IDX_W-1:0] m_slot_used;
    logic                  m_stolen;
    logic                  m_error;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;

    lru_voice_slot_allocator_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_note_number (s_note_number),
        .s_slot_index  (s_slot_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot_used   (m_slot_used),
        .m_stolen      (m_stolen),
        .m_error       (m_error)
    );

    lru_voice_slot_allocator_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_note_number (s_note_number),
        .s_slot_index  (s_slot_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot_used   (m_slot_used),
        .m_stolen      (m_stolen),
        .m_error       (m_error),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL lru_voice_slot_allocator_core");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 31);
            end
        end
    end

    // called just after aclk rises; returns once s_ready has taken the beat
    task automatic send_beat(func_t f, logic [NOTE_W-1:0] note, logic [SLOT_IDX_W-1:0] idx);
        while (!calm && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= f;
        s_note_number <= note;
        s_slot_index  <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int act_pct;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // releases with nothing active
        send_beat(FUNC_DEACTIVATE, 7'h00, 4'd0);
        send_beat(FUNC_DEACTIVATE, 7'h7f, 4'd15);
        // fill the whole table, then one more forces a steal of slot 0
        for (int k = 0; k < 16; k++)
            send_beat(FUNC_ACTIVATE, (k == 0) ? 7'h00 : (k == 1) ? 7'h7f
                      : 7'($urandom_range(127)), 4'($urandom_range(15)));
        send_beat(FUNC_ACTIVATE, 7'h7f, 4'd0);
        // unlink slot 5 from the middle, release it again (an error), then oldest and newest
        send_beat(FUNC_DEACTIVATE, 7'h55, 4'd5);
        send_beat(FUNC_DEACTIVATE, 7'h2a, 4'd5);
        send_beat(FUNC_DEACTIVATE, 7'h00, 4'd1);
        send_beat(FUNC_DEACTIVATE, 7'h7f, 4'd0);
        send_beat(FUNC_ACTIVATE, 7'h55, 4'd15);
        send_beat(FUNC_ACTIVATE, 7'h2a, 4'd10);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(3))
                0: act_pct = 20;
                1: act_pct = 50;
                2: act_pct = 80;
                default: act_pct = 95;
            endcase
            calm = (ph == 2) || (ph == 5);
            if (ph == 5) begin
                // stall the result side while beats keep coming
                hold_req <= 1'b1;
                act_pct = 60;
            end
            if (ph == 9)
                drain_results();
            for (int b = 0; b < PHASE_BEATS; b++)
                send_beat(($urandom_range(99) < act_pct) ? FUNC_ACTIVATE : FUNC_DEACTIVATE,
                          7'($urandom_range(127)), 4'($urandom_range(15)));
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS lru_voice_slot_allocator_core");
        else
            $display("FAIL lru_voice_slot_allocator_core");
        $finish;
    end

endmodule

FILE: filelist.f
src/lvsa_pkg.sv
src/lvsa_slot_table.sv
src/lru_voice_slot_allocator_core.sv
tb/sv/lru_voice_slot_allocator_checker.sv
tb/sv/lru_voice_slot_allocator_core_tb.sv
